>>> sv/circular_ranked_sequence_macros.svh
// assertion macros for the ranked sequence block
`ifndef CIRCULAR_RANKED_SEQUENCE_MACROS_SVH
`define CIRCULAR_RANKED_SEQUENCE_MACROS_SVH
`ifndef SYNTHESIS
`define CRS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("crs assertion failed");
`define CRS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("crs assertion failed");
`else
`define CRS_ASSERT(lbl, clk, rst_n, prop)
`define CRS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> sv/crs_pkg.sv
package crs_pkg;

    localparam int DEPTH_DEF     = 256;
    localparam int WORD_BITS_DEF = 32;

    localparam int REQ_TYPE_W = 3;
    localparam int RANK_W     = 8;
    localparam int ELEMENT_W  = 32;
    localparam int DATA_OUT_W = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 8;

    localparam logic [REQ_TYPE_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [REQ_TYPE_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [REQ_TYPE_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [REQ_TYPE_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [REQ_TYPE_W-1:0] OP_INSERT     = 3'd4;
    localparam logic [REQ_TYPE_W-1:0] OP_REMOVE     = 3'd5;
    localparam logic [REQ_TYPE_W-1:0] OP_GET        = 3'd6;
    localparam logic [REQ_TYPE_W-1:0] OP_SET        = 3'd7;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [DATA_OUT_W-1:0] data_out;
        logic [STATUS_W-1:0]   status;
        logic [COUNT_W-1:0]    count;
    } t_crs_result;

    typedef struct packed {
        logic idle;
        logic full;
    } t_crs_stat;

endpackage

>>> sv/crs_if.sv
interface crs_req_if;
    import crs_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [RANK_W-1:0]     rank;
    logic [ELEMENT_W-1:0]  element;

    modport source (output valid, output req_type, output rank, output element, input ready);
    modport sink   (input valid, input req_type, input rank, input element, output ready);
endinterface

interface crs_rsp_if;
    import crs_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [DATA_OUT_W-1:0] data_out;
    logic [STATUS_W-1:0]   status;
    logic [COUNT_W-1:0]    count;

    modport source (output valid, output data_out, output status, output count, input ready);
    modport sink   (input valid, input data_out, input status, input count, output ready);
endinterface

>>> sv/crs_ctrl.sv
module crs_ctrl #(
    parameter int DEPTH     = crs_pkg::DEPTH_DEF,
    parameter int WORD_BITS = crs_pkg::WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    crs_req_if.sink              i_req,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output crs_pkg::t_crs_result o_res,
    output crs_pkg::t_crs_stat   o_stat
);
    import crs_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMP_W = ((IDX_W > RANK_W) ? IDX_W : RANK_W) + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    function automatic logic [IDX_W-1:0] f_next(input logic [IDX_W-1:0] i);
        if (i == IDX_W'(DEPTH - 1)) begin
            return '0;
        end
        return i + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] f_prev(input logic [IDX_W-1:0] i);
        if (i == '0) begin
            return IDX_W'(DEPTH - 1);
        end
        return i - IDX_W'(1);
    endfunction

    logic [WORD_BITS-1:0]  r_mem [DEPTH];
    logic [WORD_BITS-1:0]  r_q;

    logic [2:0]            r_state, n_state;
    logic [REQ_TYPE_W-1:0] r_op, n_op;
    logic [RANK_W-1:0]     r_rank, n_rank;
    logic [WORD_BITS-1:0]  r_word, n_word;
    logic [IDX_W-1:0]      r_front, n_front;
    logic [IDX_W-1:0]      r_back, n_back;
    logic [IDX_W-1:0]      r_src, n_src;
    logic [IDX_W-1:0]      r_wadr, n_wadr;
    logic [IDX_W-1:0]      r_left, n_left;
    logic                  r_wpend, n_wpend;
    logic                  r_up, n_up;
    logic [IDX_W-1:0]      r_slot, n_slot;
    logic [WORD_BITS-1:0]  r_data, n_data;
    logic [STATUS_W-1:0]   r_status, n_status;

    logic                  w_we, w_re;
    logic [IDX_W-1:0]      w_wa, w_ra;
    logic [WORD_BITS-1:0]  w_wd;

    logic [IDX_W:0]        w_diff, w_cnt_ext;
    logic [IDX_W-1:0]      w_cnt;
    logic                  w_full, w_empty;
    logic [CMP_W-1:0]      w_rank_c, w_cnt_c, w_sum, w_slot_c, w_m_ins, w_m_rem;
    logic [IDX_W-1:0]      w_slot;
    logic [63:0]           w_elem64, w_data64, w_cnt64;

    // occupancy and rank to slot mapping
    always_comb begin
        w_diff    = {1'b0, r_back} - {1'b0, r_front};
        w_cnt_ext = (r_back >= r_front) ? w_diff : w_diff + (IDX_W + 1)'(DEPTH);
        w_cnt     = w_cnt_ext[IDX_W-1:0];
        w_full    = (w_cnt == IDX_W'(DEPTH - 1));
        w_empty   = (w_cnt == '0);
        w_rank_c  = CMP_W'(r_rank);
        w_cnt_c   = CMP_W'(w_cnt);
        w_sum     = CMP_W'(r_front) + w_rank_c;
        w_slot_c  = (w_sum >= CMP_W'(DEPTH)) ? w_sum - CMP_W'(DEPTH) : w_sum;
        w_slot    = w_slot_c[IDX_W-1:0];
        w_m_ins   = w_cnt_c - w_rank_c;
        w_m_rem   = w_cnt_c - w_rank_c - CMP_W'(1);
        w_elem64  = 64'(i_req.element);
        w_data64  = 64'(r_data);
        w_cnt64   = 64'(w_cnt);
    end

    always_comb begin
        logic do_pf, do_pb, do_popf, do_popb;

        do_pf    = 1'b0;
        do_pb    = 1'b0;
        do_popf  = 1'b0;
        do_popb  = 1'b0;
        n_state  = r_state;
        n_op     = r_op;
        n_rank   = r_rank;
        n_word   = r_word;
        n_front  = r_front;
        n_back   = r_back;
        n_src    = r_src;
        n_wadr   = r_wadr;
        n_left   = r_left;
        n_wpend  = r_wpend;
        n_up     = r_up;
        n_slot   = r_slot;
        n_data   = r_data;
        n_status = r_status;
        w_we     = 1'b0;
        w_wa     = r_wadr;
        w_wd     = r_q;
        w_re     = 1'b0;
        w_ra     = r_src;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op    = i_req.req_type;
                    n_rank  = i_req.rank;
                    n_word  = w_elem64[WORD_BITS-1:0];
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_data   = '0;
                n_status = ST_OK;
                n_left   = '0;
                n_wpend  = 1'b0;
                n_state  = S_DONE;
                case (r_op)
                    OP_PUSH_FRONT: begin
                        if (w_full) n_status = ST_FULL;
                        else        do_pf = 1'b1;
                    end
                    OP_PUSH_BACK: begin
                        if (w_full) n_status = ST_FULL;
                        else        do_pb = 1'b1;
                    end
                    OP_POP_FRONT: begin
                        if (w_empty) n_status = ST_BAD;
                        else         do_popf = 1'b1;
                    end
                    OP_POP_BACK: begin
                        if (w_empty) n_status = ST_BAD;
                        else         do_popb = 1'b1;
                    end
                    OP_INSERT: begin
                        if (w_rank_c > w_cnt_c) begin
                            n_status = ST_BAD;
                        end else if (w_full) begin
                            n_status = ST_FULL;
                        end else if (r_rank == '0) begin
                            do_pf = 1'b1;
                        end else if (w_rank_c == w_cnt_c) begin
                            do_pb = 1'b1;
                        end else begin
                            // move the tail up one slot, last word first
                            n_left  = w_m_ins[IDX_W-1:0];
                            n_src   = f_prev(r_back);
                            n_up    = 1'b1;
                            n_slot  = w_slot;
                            n_state = S_SHIFT;
                        end
                    end
                    OP_REMOVE: begin
                        if (w_rank_c >= w_cnt_c) begin
                            n_status = ST_BAD;
                        end else if (r_rank == '0) begin
                            do_popf = 1'b1;
                        end else if (w_rank_c == w_cnt_c - CMP_W'(1)) begin
                            do_popb = 1'b1;
                        end else begin
                            w_re    = 1'b1;
                            w_ra    = w_slot;
                            n_left  = w_m_rem[IDX_W-1:0];
                            n_src   = f_next(w_slot);
                            n_up    = 1'b0;
                            n_slot  = w_slot;
                            n_state = S_RD;
                        end
                    end
                    OP_GET: begin
                        if (w_rank_c >= w_cnt_c) begin
                            n_status = ST_BAD;
                        end else begin
                            w_re    = 1'b1;
                            w_ra    = w_slot;
                            n_state = S_RD;
                        end
                    end
                    OP_SET: begin
                        if (w_rank_c >= w_cnt_c) begin
                            n_status = ST_BAD;
                        end else begin
                            // the read in the same cycle as the write returns the old word
                            w_re    = 1'b1;
                            w_ra    = w_slot;
                            w_we    = 1'b1;
                            w_wa    = w_slot;
                            w_wd    = r_word;
                            n_state = S_RD;
                        end
                    end
                    default: begin
                        n_status = ST_BAD;
                    end
                endcase
                if (do_pf) begin
                    w_we    = 1'b1;
                    w_wa    = f_prev(r_front);
                    w_wd    = r_word;
                    n_front = f_prev(r_front);
                end
                if (do_pb) begin
                    w_we   = 1'b1;
                    w_wa   = r_back;
                    w_wd   = r_word;
                    n_back = f_next(r_back);
                end
                if (do_popf) begin
                    w_re    = 1'b1;
                    w_ra    = r_front;
                    n_front = f_next(r_front);
                    n_state = S_RD;
                end
                if (do_popb) begin
                    w_re    = 1'b1;
                    w_ra    = f_prev(r_back);
                    n_back  = f_prev(r_back);
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_data  = r_q;
                n_state = (r_left != '0) ? S_SHIFT : S_DONE;
            end
            S_SHIFT: begin
                // one read and the write of the word read last cycle
                if (r_wpend) begin
                    w_we = 1'b1;
                    w_wa = r_wadr;
                    w_wd = r_q;
                end
                if (r_left != '0) begin
                    w_re    = 1'b1;
                    w_ra    = r_src;
                    n_wpend = 1'b1;
                    n_wadr  = r_up ? f_next(r_src) : f_prev(r_src);
                    n_src   = r_up ? f_prev(r_src) : f_next(r_src);
                    n_left  = r_left - IDX_W'(1);
                end else begin
                    n_wpend = 1'b0;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (r_up) begin
                    w_we   = 1'b1;
                    w_wa   = r_slot;
                    w_wd   = r_word;
                    n_back = f_next(r_back);
                end else begin
                    n_back = f_prev(r_back);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_re) begin
            r_q <= r_mem[w_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_back  <= '0;
            r_left  <= '0;
            r_wpend <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_back  <= n_back;
            r_left  <= n_left;
            r_wpend <= n_wpend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_rank   <= n_rank;
        r_word   <= n_word;
        r_src    <= n_src;
        r_wadr   <= n_wadr;
        r_up     <= n_up;
        r_slot   <= n_slot;
        r_data   <= n_data;
        r_status <= n_status;
    end

    assign i_req.ready    = (r_state == S_IDLE);
    assign o_res_valid    = (r_state == S_DONE);
    assign o_res.data_out = w_data64[DATA_OUT_W-1:0];
    assign o_res.status   = r_status;
    assign o_res.count    = w_cnt64[COUNT_W-1:0];
    assign o_stat.idle    = (r_state == S_IDLE);
    assign o_stat.full    = w_full;

endmodule

>>> sv/crs_out_stage.sv
module crs_out_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  crs_pkg::t_crs_result i_res,
    crs_rsp_if.source            o_rsp
);
    import crs_pkg::*;

    logic        r_valid, n_valid;
    t_crs_result r_res, n_res;

    always_comb begin
        n_valid = r_valid;
        n_res   = r_res;
        if (o_rsp.ready) begin
            n_valid = 1'b0;
        end
        if (o_ready && i_valid) begin
            n_valid = 1'b1;
            n_res   = i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_ready        = !r_valid || o_rsp.ready;
    assign o_rsp.valid    = r_valid;
    assign o_rsp.data_out = r_res.data_out;
    assign o_rsp.status   = r_res.status;
    assign o_rsp.count    = r_res.count;

endmodule

>>> sv/circular_ranked_sequence.sv
// Deque and rank-addressed sequence of words kept in a ring of DEPTH memory slots, of which
// at most DEPTH-1 hold words. One request is worked at a time and gives one transaction on the
// response side. The next request is taken only after the output register has accepted
// the result of the last one. Insert and remove at an inner rank move every word behind
// that rank one slot through the single read and single write port of the slot memory,
// one word a cycle; up to DEPTH-3 words move. A finished response waits in an output
// register, so the block is ready for the next request while it is still held. No clearing
// pass is needed after reset.
`include "circular_ranked_sequence_macros.svh"

module circular_ranked_sequence #(
    parameter int DEPTH     = crs_pkg::DEPTH_DEF,
    parameter int WORD_BITS = crs_pkg::WORD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    crs_req_if.sink   i_req,
    crs_rsp_if.source o_rsp
);
    import crs_pkg::*;

    logic        w_res_valid;
    logic        w_res_ready;
    t_crs_result w_res;
    t_crs_stat   w_stat;

    crs_ctrl #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_stat      (w_stat)
    );

    crs_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_res_valid),
        .o_ready (w_res_ready),
        .i_res   (w_res),
        .o_rsp   (o_rsp)
    );

    `CRS_ASSERT(a_accept_starts_work, i_clk, i_rst_n, i_req.valid && i_req.ready |=> !w_stat.idle)
    `CRS_ASSERT(a_no_accept_with_result, i_clk, i_rst_n, i_req.ready |-> !w_res_valid)
    `CRS_ASSERT(a_full_status_when_full, i_clk, i_rst_n, w_res_valid && (w_res.status == ST_FULL) |-> w_stat.full)
    `CRS_ASSERT(a_error_data_zero, i_clk, i_rst_n, w_res_valid && (w_res.status != ST_OK) |-> (w_res.data_out == '0))

endmodule
